### hdl/rwm_pkg.sv
// Shared types and constants of the residency window monitor.
`timescale 1ns / 1ps

package rwm_pkg;

  // Default parameter values of the top level.
  localparam int MAX_RESIDENT_DEF   = 4096;
  localparam int TIME_BITS_DEF      = 48;
  localparam int MEAN_FRAC_BITS_DEF = 8;

  // Fixed field and accumulator widths.
  localparam int DELTA_W   = 14;
  localparam int START_W   = 13;
  localparam int PEAK_W    = 13;
  localparam int MEAN_W    = 21;
  localparam int STARTS_W  = 32;
  localparam int AREA_W    = 64;
  localparam int CFG_IDX_W = 1;

  localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BEGIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 1'b1;

  // Operation of the shared adder.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic load_item;
    logic span;
    logic mul_step;
    logic acc;
    logic update;
    logic div_step;
    logic finish;
  } rwm_ctl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic overlap;
    logic last;
    logic end_ok;
  } rwm_sts_t;

endpackage

### hdl/rwm_alu.sv
// Shared 64-bit adder and subtractor with carry out.
`timescale 1ns / 1ps

module rwm_alu (
  input  logic [rwm_pkg::AREA_W-1:0] a,
  input  logic [rwm_pkg::AREA_W-1:0] b,
  input  rwm_pkg::alu_op_t           op,
  output logic [rwm_pkg::AREA_W-1:0] sum,
  output logic                       carry
);
  import rwm_pkg::*;

  logic [AREA_W-1:0] b_eff;
  logic [AREA_W:0]   full;

  // On subtraction a set carry means no borrow, that is a >= b.
  always_comb begin
    b_eff = (op == ALU_SUB) ? ~b : b;
    full  = {1'b0, a} + {1'b0, b_eff} + {{AREA_W{1'b0}}, (op == ALU_SUB)};
  end

  assign sum   = full[AREA_W-1:0];
  assign carry = full[AREA_W];

endmodule

### hdl/rwm_ctrl.sv
// Sequencer that steps the shared adder through one event.
`timescale 1ns / 1ps

module rwm_ctrl #(
  parameter int MUL_STEPS = 13,
  parameter int DIV_STEPS = 72
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_busy,
  input  rwm_pkg::rwm_sts_t sts,
  output logic              in_ready,
  output rwm_pkg::rwm_ctl_t ctl
);
  import rwm_pkg::*;

  localparam int MAX_STEPS = (DIV_STEPS > MUL_STEPS) ? DIV_STEPS : MUL_STEPS;
  localparam int CNT_W     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPAN,
    S_MUL,
    S_ACC,
    S_UPDATE,
    S_DIV,
    S_FINISH
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_SPAN;
        end
        S_SPAN: begin
          if (sts.overlap) begin
            state <= S_MUL;
            cnt   <= CNT_W'(MUL_STEPS - 1);
          end else begin
            state <= S_UPDATE;
          end
        end
        S_MUL: begin
          if (cnt == '0) state <= S_ACC;
          else cnt <= cnt - 1'b1;
        end
        S_ACC: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (!sts.last) begin
            state <= S_IDLE;
          end else if (sts.end_ok) begin
            state <= S_DIV;
            cnt   <= CNT_W'(DIV_STEPS - 1);
          end else begin
            state <= S_FINISH;
          end
        end
        S_DIV: begin
          if (cnt == '0) state <= S_FINISH;
          else cnt <= cnt - 1'b1;
        end
        S_FINISH: begin
          if (!out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl           = '0;
    ctl.load_item = (state == S_IDLE) && in_valid;
    ctl.span      = (state == S_SPAN);
    ctl.mul_step  = (state == S_MUL);
    ctl.acc       = (state == S_ACC);
    ctl.update    = (state == S_UPDATE);
    ctl.div_step  = (state == S_DIV);
    ctl.finish    = (state == S_FINISH) && !out_busy;
  end

endmodule

### hdl/residency_window_monitor_unit.sv
// Top level of the residency window monitor: registers, datapath and result stage.
`timescale 1ns / 1ps
// Sequence: an event whose interval misses the window goes from the span step to the update
// step; one that overlaps it runs the bit-serial multiply on the shared 64-bit adder and an
// accumulate step first. The last event adds a restoring division on the same adder, when the
// run ended valid and empty with a nonempty window, and a result step that waits while a result is pending.
// Reset (synchronous, active high) clears the window registers and the run state to zero,
// with the first-event and run-valid flags set, and drops out_valid; no clearing pass.

module residency_window_monitor_unit #(
  parameter int MAX_RESIDENT   = rwm_pkg::MAX_RESIDENT_DEF,
  parameter int TIME_BITS      = rwm_pkg::TIME_BITS_DEF,
  parameter int MEAN_FRAC_BITS = rwm_pkg::MEAN_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rwm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [TIME_BITS-1:0]                cfg_data,
  // Event channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [TIME_BITS-1:0]                event_time,
  input  logic signed [rwm_pkg::DELTA_W-1:0]  resident_delta,
  input  logic [rwm_pkg::START_W-1:0]         start_count,
  input  logic                                last_event,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                available,
  output logic [rwm_pkg::MEAN_W-1:0]          mean_resident_q8,
  output logic [rwm_pkg::PEAK_W-1:0]          peak_resident,
  output logic [rwm_pkg::STARTS_W-1:0]        starts_in_window,
  output logic [rwm_pkg::STARTS_W-1:0]        starts_total
);
  import rwm_pkg::*;

  // Resident count width, and the signed width that holds count plus delta.
  localparam int RW        = $clog2(MAX_RESIDENT + 1);
  localparam int NR_W      = ((RW > DELTA_W - 1) ? RW : DELTA_W - 1) + 2;
  localparam int DIV_STEPS = AREA_W + MEAN_FRAC_BITS;

  // Window registers, written through the configuration channel.
  logic [TIME_BITS-1:0] window_begin;
  logic [TIME_BITS-1:0] window_end;

  // The event being worked on.
  logic [TIME_BITS-1:0]      t_reg;
  logic signed [DELTA_W-1:0] delta_reg;
  logic [START_W-1:0]        sc_reg;
  logic                      last_reg;

  // Run state.
  logic [RW-1:0]        resident_count;
  logic [TIME_BITS-1:0] previous_time;
  logic                 first_pending;
  logic [AREA_W-1:0]    area_sum;
  logic [RW-1:0]        peak_seen;
  logic [STARTS_W-1:0]  window_starts;
  logic [STARTS_W-1:0]  total_starts;
  logic                 run_valid;

  // Working registers of the interval, multiply and divide steps.
  logic [TIME_BITS-1:0] d_reg;
  logic                 in_win;
  logic [TIME_BITS-1:0] span_reg;
  logic                 span_ok;
  logic [RW-1:0]        mulr;
  logic [AREA_W-1:0]    acc;
  logic                 mul_ovf;
  logic                 end_ok;
  logic [AREA_W-1:0]    dvd;
  logic [TIME_BITS-1:0] rem;
  logic [MEAN_W-1:0]    quo;
  logic                 quo_ovf;

  rwm_ctl_t ctl;
  rwm_sts_t sts;
  logic     out_busy;

  // Shared adder.
  logic [AREA_W-1:0] alu_a;
  logic [AREA_W-1:0] alu_b;
  alu_op_t           alu_op;
  logic [AREA_W-1:0] alu_sum;
  logic              alu_carry;

  // Combinational helpers.
  logic [TIME_BITS-1:0]  lo;
  logic [TIME_BITS-1:0]  hi;
  logic                  overlap;
  logic [TIME_BITS-1:0]  dur;
  logic signed [NR_W-1:0] nr;
  logic [RW-1:0]         count_next;
  logic                  valid_next;
  logic                  end_ok_next;
  logic [STARTS_W:0]     ws_sum;
  logic [STARTS_W:0]     ts_sum;
  logic [TIME_BITS:0]    rem_shift;

  assign cfg_ready = 1'b1;
  assign out_busy  = out_valid && !out_ready;

  rwm_ctrl #(
    .MUL_STEPS (RW),
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .sts      (sts),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  rwm_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .op    (alu_op),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  // Overlap of the interval from the previous event to this one with the window.
  always_comb begin
    lo      = (previous_time > window_begin) ? previous_time : window_begin;
    hi      = (t_reg < window_end) ? t_reg : window_end;
    overlap = (hi > lo);
    dur     = hi - lo;
  end

  // Resident count update with clamping; any excursion spoils the run.
  always_comb begin
    nr = $signed(NR_W'(resident_count)) + NR_W'(delta_reg);
    valid_next = run_valid;
    count_next = nr[RW-1:0];
    if (nr < 0) begin
      valid_next = 1'b0;
      count_next = '0;
    end else if (nr > $signed(NR_W'(MAX_RESIDENT))) begin
      valid_next = 1'b0;
      count_next = RW'(MAX_RESIDENT);
    end
    end_ok_next = valid_next && (count_next == '0) && span_ok;
    ws_sum = {1'b0, window_starts} + (STARTS_W + 1)'(sc_reg);
    ts_sum = {1'b0, total_starts} + (STARTS_W + 1)'(sc_reg);
  end

  assign rem_shift = {rem, dvd[AREA_W-1]};

  // Operand selection for the shared adder. The multiply runs MSB first over the resident
  // count, doubling the partial product and adding the duration where the bit is set. The
  // divide is a restoring long division of area * 2^MEAN_FRAC_BITS by the window length.
  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = ALU_ADD;
    if (ctl.mul_step) begin
      alu_a = {acc[AREA_W-2:0], 1'b0};
      alu_b = mulr[RW-1] ? AREA_W'(d_reg) : '0;
    end else if (ctl.acc) begin
      alu_a = area_sum;
      alu_b = mul_ovf ? '1 : acc;
    end else if (ctl.div_step) begin
      alu_a  = AREA_W'(rem_shift);
      alu_b  = AREA_W'(span_reg);
      alu_op = ALU_SUB;
    end
  end

  always_comb begin
    sts         = '0;
    sts.overlap = overlap;
    sts.last    = last_reg;
    sts.end_ok  = end_ok_next;
  end

  // Control and run state.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_begin   <= '0;
      window_end     <= '0;
      resident_count <= '0;
      previous_time  <= '0;
      first_pending  <= 1'b1;
      area_sum       <= '0;
      peak_seen      <= '0;
      window_starts  <= '0;
      total_starts   <= '0;
      run_valid      <= 1'b1;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_BEGIN: window_begin <= cfg_data;
          REG_WINDOW_END:   window_end   <= cfg_data;
          default: ;
        endcase
      end

      // The first event of a run opens its interval at its own time.
      if (ctl.load_item && first_pending) begin
        previous_time <= event_time;
        first_pending <= 1'b0;
      end

      if (ctl.acc) begin
        area_sum <= alu_carry ? '1 : alu_sum;
        if (resident_count > peak_seen) peak_seen <= resident_count;
      end

      if (ctl.update) begin
        resident_count <= count_next;
        run_valid      <= valid_next;
        previous_time  <= t_reg;
        total_starts   <= ts_sum[STARTS_W] ? '1 : ts_sum[STARTS_W-1:0];
        if (in_win) begin
          window_starts <= ws_sum[STARTS_W] ? '1 : ws_sum[STARTS_W-1:0];
        end
      end

      // Handing over the result returns the run to its reset values.
      if (ctl.finish) begin
        out_valid      <= 1'b1;
        resident_count <= '0;
        previous_time  <= '0;
        first_pending  <= 1'b1;
        area_sum       <= '0;
        peak_seen      <= '0;
        window_starts  <= '0;
        total_starts   <= '0;
        run_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      t_reg     <= event_time;
      delta_reg <= resident_delta;
      sc_reg    <= start_count;
      last_reg  <= last_event;
    end

    if (ctl.span) begin
      d_reg    <= dur;
      mulr     <= resident_count;
      acc      <= '0;
      mul_ovf  <= 1'b0;
      in_win   <= (t_reg >= window_begin) && (t_reg < window_end);
      span_reg <= window_end - window_begin;
      span_ok  <= (window_end > window_begin);
    end

    if (ctl.mul_step) begin
      acc     <= alu_sum;
      mul_ovf <= mul_ovf | acc[AREA_W-1] | alu_carry;
      mulr    <= {mulr[RW-2:0], 1'b0};
    end

    // The area is final once the update cycle is reached.
    if (ctl.update) begin
      end_ok  <= end_ok_next;
      dvd     <= area_sum;
      rem     <= '0;
      quo     <= '0;
      quo_ovf <= 1'b0;
    end

    // A quotient bit pushed out of the top of the field means saturation.
    if (ctl.div_step) begin
      rem     <= alu_carry ? alu_sum[TIME_BITS-1:0] : rem_shift[TIME_BITS-1:0];
      dvd     <= {dvd[AREA_W-2:0], 1'b0};
      quo     <= {quo[MEAN_W-2:0], alu_carry};
      quo_ovf <= quo_ovf | quo[MEAN_W-1];
    end

    if (ctl.finish) begin
      available        <= end_ok;
      mean_resident_q8 <= end_ok ? (quo_ovf ? MEAN_MAX : quo) : '0;
      peak_resident    <= end_ok ? PEAK_W'(peak_seen) : '0;
      starts_in_window <= window_starts;
      starts_total     <= total_starts;
    end
  end

`ifndef SYNTHESIS
  // Once an event is taken, the block works on it before taking another.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("event accepted while previous one still in progress");

  // A result is only raised by the sequencer's hand-over step.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.finish))
    else $error("result raised outside the hand-over step");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  // An invalid run reports neither mean nor peak.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !available |-> (mean_resident_q8 == '0) && (peak_resident == '0))
    else $error("invalid run reports nonzero mean or peak");
`endif

endmodule
